// ===== rtl/bair_pkg.sv =====
package bair_pkg;

   localparam int MAX_SRC_WIDTH  = 512;
   localparam int MAX_SRC_HEIGHT = 512;

   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SX_W   = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SY_W   = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int CRD_W  = 12;
   localparam int DSZ_W  = 13;
   localparam int SSZ_W  = 10;
   localparam int BPP_W  = 3;
   localparam int CSR_W  = 13;
   localparam int IDX_W  = 3;
   localparam int LANES  = 4;

   localparam int AREA_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = 8 + AREA_W;
   localparam int BOX_W  = DSZ_W + ((SX_W > SY_W) ? SX_W : SY_W);
   localparam int DIV_W  = (SUM_W > BOX_W) ? SUM_W : BOX_W;
   localparam int DVS_W  = (AREA_W > DSZ_W) ? AREA_W : DSZ_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   localparam logic [IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] CSR_BPP        = 3'd4;

   typedef struct packed {
      logic clear;
      logic acc_en;
      logic sum_sel;
      logic start;
   } lane_ctl_type;

endpackage

// ===== rtl/bair_div.sv =====
module bair_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bair_pkg::DIV_W-1:0]   dividend,
   input  logic [bair_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [bair_pkg::DIV_W-1:0]   quotient
);
   import bair_pkg::*;

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   // Restoring division, one quotient bit per cycle; the dividend shifts out
   // of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/bair_lane.sv =====
module bair_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  bair_pkg::lane_ctl_type       ctl,
   input  logic [7:0]                   pix_byte,
   input  logic [bair_pkg::DIV_W-1:0]   box_dividend,
   input  logic [bair_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [bair_pkg::DIV_W-1:0]   quotient
);
   import bair_pkg::*;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [DIV_W-1:0] dvd;

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.acc_en) begin
         sum_in = sum_ff + SUM_W'(pix_byte);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // The divider first finds a box edge, later the channel average.
   assign dvd = ctl.sum_sel ? DIV_W'(sum_ff) : box_dividend;

   bair_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.start),
      .dividend (dvd),
      .divisor  (divisor),
      .done     (done),
      .quotient (quotient)
   );

endmodule

// ===== rtl/bair_store.sv =====
module bair_store (
   input  logic                          clock,
   input  logic                          we,
   input  logic [bair_pkg::ADDR_W-1:0]   addr,
   input  logic [31:0]                   wdata,
   output logic [31:0]                   rdata
);
   import bair_pkg::*;

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/box_average_image_resize_unit.sv =====
// Pixel writes are accepted back to back while no pixel request is in progress.
// A pixel request on a box of W x H source pixels runs two bit-serial divisions
// per lane and reads the box from the store at one pixel a cycle.
// One request is worked on at a time.
// Reset is synchronous: sizes return to 512x512 -> 256x256, four channels.
// The pixel store is not cleared by reset.
module box_average_image_resize_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [55:0]                req_tdata,  // coord_x, coord_y, pixel_in
   input  logic                       req_tuser,  // action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,  // dest_x, dest_y, pixel_out
   input  logic                       csr_we,
   input  logic [bair_pkg::IDX_W-1:0] csr_index,
   input  logic [bair_pkg::CSR_W-1:0] csr_wdata
);
   import bair_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_MUL   = 10'b0000000010,
      ST_BOXGO = 10'b0000000100,
      ST_BOX   = 10'b0000001000,
      ST_AREA  = 10'b0000010000,
      ST_SCAN  = 10'b0000100000,
      ST_DRAIN = 10'b0001000000,
      ST_AVGGO = 10'b0010000000,
      ST_AVG   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [SSZ_W-1:0] src_w_ff, src_h_ff;
   logic [DSZ_W-1:0] dst_w_ff, dst_h_ff;
   logic [BPP_W-1:0] bpp_ff;

   logic [SX_W-1:0]  sw;
   logic [SY_W-1:0]  sh;
   logic [DSZ_W-1:0] dw, dh;
   logic [BPP_W-1:0] nch;

   logic [CRD_W-1:0] req_x, req_y;
   logic [31:0]      req_pix;
   logic             req_xfer;

   logic [CRD_W-1:0] cx_ff, cy_ff;
   logic [DIV_W-1:0] box_dvd_ff [LANES];
   logic [SX_W-1:0]  x0_ff, x1_ff, sx_ff;
   logic [SY_W-1:0]  y0_ff, y1_ff, sy_ff;
   logic [AREA_W-1:0] area_ff;
   logic             rd_vld_ff;

   logic [SX_W-1:0]  q0x, q1x;
   logic [SY_W-1:0]  q0y, q1y;

   logic             rsp_vld_ff;
   logic [55:0]      rsp_data_ff;
   logic [31:0]      merged;

   lane_ctl_type     ctl;
   logic [DVS_W-1:0] lane_dvs [LANES];
   logic [LANES-1:0] lane_done;
   logic [DIV_W-1:0] lane_quo [LANES];

   logic             mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0]      mem_rdata;

   assign req_x   = req_tdata[11:0];
   assign req_y   = req_tdata[23:12];
   assign req_pix = req_tdata[55:24];

   // Effective sizes after the out-of-range rules.
   always_comb begin
      if (src_w_ff == '0) begin
         sw = SX_W'(1);
      end else if (SX_W'(src_w_ff) > SX_W'(MAX_SRC_WIDTH)) begin
         sw = SX_W'(MAX_SRC_WIDTH);
      end else begin
         sw = SX_W'(src_w_ff);
      end
      if (src_h_ff == '0) begin
         sh = SY_W'(1);
      end else if (SY_W'(src_h_ff) > SY_W'(MAX_SRC_HEIGHT)) begin
         sh = SY_W'(MAX_SRC_HEIGHT);
      end else begin
         sh = SY_W'(src_h_ff);
      end
      dw  = (dst_w_ff == '0) ? DSZ_W'(1) : dst_w_ff;
      dh  = (dst_h_ff == '0) ? DSZ_W'(1) : dst_h_ff;
      nch = (bpp_ff > BPP_W'(LANES)) ? BPP_W'(LANES) : bpp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SSZ_W'(512);
         src_h_ff <= SSZ_W'(512);
         dst_w_ff <= DSZ_W'(256);
         dst_h_ff <= DSZ_W'(256);
         bpp_ff   <= BPP_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SSZ_W-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SSZ_W-1:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DSZ_W-1:0];
            CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DSZ_W-1:0];
            CSR_BPP:        bpp_ff   <= csr_wdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser && DSZ_W'(req_x) < dw && DSZ_W'(req_y) < dh) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_BOXGO;
         ST_BOXGO: state_in = ST_BOX;
         ST_BOX: begin
            if (lane_done[0]) begin
               state_in = ST_AREA;
            end
         end
         ST_AREA:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (sx_ff + 1'b1 == x1_ff && sy_ff + 1'b1 == y1_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_AVGGO;
         ST_AVGGO: state_in = ST_AVG;
         ST_AVG: begin
            if (lane_done[0]) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   assign q0x = lane_quo[0][SX_W-1:0];
   assign q1x = lane_quo[1][SX_W-1:0];
   assign q0y = lane_quo[2][SY_W-1:0];
   assign q1y = lane_quo[3][SY_W-1:0];

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cx_ff <= req_x;
         cy_ff <= req_y;
      end
      if (state_ff == ST_MUL) begin
         box_dvd_ff[0] <= DIV_W'(cx_ff) * DIV_W'(sw);
         box_dvd_ff[1] <= (DIV_W'(cx_ff) + 1'b1) * DIV_W'(sw);
         box_dvd_ff[2] <= DIV_W'(cy_ff) * DIV_W'(sh);
         box_dvd_ff[3] <= (DIV_W'(cy_ff) + 1'b1) * DIV_W'(sh);
      end
      if (state_ff == ST_BOX && lane_done[0]) begin
         // An empty extent is widened to one pixel.
         x0_ff <= q0x;
         x1_ff <= (q1x <= q0x) ? q0x + 1'b1 : q1x;
         y0_ff <= q0y;
         y1_ff <= (q1y <= q0y) ? q0y + 1'b1 : q1y;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= AREA_W'(x1_ff - x0_ff) * AREA_W'(y1_ff - y0_ff);
         sx_ff   <= x0_ff;
         sy_ff   <= y0_ff;
      end else if (state_ff == ST_SCAN) begin
         if (sx_ff + 1'b1 == x1_ff) begin
            sx_ff <= x0_ff;
            sy_ff <= sy_ff + 1'b1;
         end else begin
            sx_ff <= sx_ff + 1'b1;
         end
      end
   end

   assign mem_we = req_xfer && !req_tuser && req_x < CRD_W'(MAX_SRC_WIDTH)
                   && req_y < CRD_W'(MAX_SRC_HEIGHT);

   always_comb begin
      if (state_ff == ST_SCAN) begin
         mem_addr = ADDR_W'(ADDR_W'(sy_ff) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sx_ff));
      end else begin
         mem_addr = ADDR_W'(ADDR_W'(req_y) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(req_x));
      end
   end

   bair_store u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_pix),
      .rdata (mem_rdata)
   );

   always_comb begin
      ctl.clear   = (state_ff == ST_BOXGO);
      ctl.acc_en  = rd_vld_ff;
      ctl.sum_sel = (state_ff == ST_AVGGO);
      ctl.start   = (state_ff == ST_BOXGO) || (state_ff == ST_AVGGO);
   end

   // Box edges: lanes 0 and 1 divide by the destination width, 2 and 3 by
   // the height. Averages: every lane divides its channel sum by the area.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == ST_AVGGO) begin
            lane_dvs[i] = DVS_W'(area_ff);
         end else if (i < 2) begin
            lane_dvs[i] = DVS_W'(dw);
         end else begin
            lane_dvs[i] = DVS_W'(dh);
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bair_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .pix_byte     (mem_rdata[8*g +: 8]),
         .box_dividend (box_dvd_ff[g]),
         .divisor      (lane_dvs[g]),
         .done         (lane_done[g]),
         .quotient     (lane_quo[g])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         merged[8*i +: 8] = (BPP_W'(i) < nch) ? lane_quo[i][7:0] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_vld_ff || rsp_tready)) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (state_ff == ST_OUT && (!rsp_vld_ff || rsp_tready)) begin
         rsp_data_ff <= {merged, cy_ff, cx_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/tb_box_average_image_resize_unit.sv =====
module tb_box_average_image_resize_unit;
   import bair_pkg::*;

   localparam logic [IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic             ACT_WRITE  = 1'b0;
   localparam logic             ACT_REQUEST = 1'b1;

   typedef struct packed {
      logic [31:0]      pixel;
      logic [CRD_W-1:0] y;
      logic [CRD_W-1:0] x;
   } pixel_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Predictor state: configuration and the pixels written so far.
   logic [SSZ_W-1:0]     cfg_src_w;
   logic [SSZ_W-1:0]     cfg_src_h;
   logic [DSZ_W-1:0]     cfg_dst_w;
   logic [DSZ_W-1:0]     cfg_dst_h;
   logic [BPP_W-1:0]     cfg_bpp;
   logic [31:0]          source_store [int];

   pixel_item_type       expected_pixels [$];
   int                   error_count = 0;
   int                   write_count = 0;
   int                   request_count = 0;
   int                   result_count = 0;
   int                   config_count = 0;
   bit                   quiet = 1'b0;
   int                   hold_left = 0;
   int                   tx_gap = 0;
   int                   rx_gap = 0;

   box_average_image_resize_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #20000000;
      $display("Timeout with %0d results still expected", expected_pixels.size());
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
   endtask

   // Area average of one destination pixel; valid is low if the request is ignored.
   function automatic logic [31:0] box_average(input int unsigned x, input int unsigned y,
                                               output bit valid);
      int unsigned sw, sh, dw, dh, nch, x0, x1, y0, y1, area;
      longint unsigned sum [4];
      logic [31:0] p, avg_pixel;
      sw = (cfg_src_w == 0) ? 1 : ((cfg_src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : cfg_src_w);
      sh = (cfg_src_h == 0) ? 1 : ((cfg_src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : cfg_src_h);
      dw = (cfg_dst_w == 0) ? 1 : cfg_dst_w;
      dh = (cfg_dst_h == 0) ? 1 : cfg_dst_h;
      nch = (cfg_bpp > 4) ? 4 : cfg_bpp;
      avg_pixel = '0;
      valid = (x < dw) && (y < dh);
      if (!valid) return '0;
      x0 = (longint'(x) * sw) / dw;
      x1 = (longint'(x + 1) * sw) / dw;
      if (x1 <= x0) x1 = x0 + 1;
      y0 = (longint'(y) * sh) / dh;
      y1 = (longint'(y + 1) * sh) / dh;
      if (y1 <= y0) y1 = y0 + 1;
      area = (x1 - x0) * (y1 - y0);
      for (int c = 0; c < 4; c++) sum[c] = 0;
      for (int unsigned ys = y0; ys < y1; ys++) begin
         for (int unsigned xs = x0; xs < x1; xs++) begin
            p = source_store.exists(ys * MAX_SRC_WIDTH + xs) ?
                source_store[ys * MAX_SRC_WIDTH + xs] : '0;
            for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
         end
      end
      for (int c = 0; c < nch; c++) avg_pixel[8*c +: 8] = 8'(sum[c] / area);
      return avg_pixel;
   endfunction

   // Receiver: random stall bursts, a long hold-off on request, and always ready when quiet.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (quiet) begin
         rsp_tready = 1'b1;
      end else if (rx_gap > 0) begin
         rsp_tready = 1'b0;
         rx_gap--;
      end else begin
         rsp_tready = 1'b1;
         if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin
      pixel_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         result_count++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transfer", got.pixel, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x) report_mismatch("dest_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("dest_y", got.y, want.y);
            if (got.pixel !== want.pixel) report_mismatch("pixel_out", got.pixel, want.pixel);
         end
      end
   end

   // Offers one item and returns at the edge of its transfer, with valid still high.
   task automatic send_item(input logic action, input int unsigned x, input int unsigned y,
                            input logic [31:0] pixel);
      pixel_item_type item;
      bit valid;
      @(negedge clock);
      if (!quiet && tx_gap == 0 && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 15);
      if (!quiet && tx_gap > 0) begin
         req_tvalid = 1'b0;
         repeat (tx_gap) @(negedge clock);
         tx_gap = 0;
      end
      item.x = x[CRD_W-1:0];
      item.y = y[CRD_W-1:0];
      item.pixel = pixel;
      req_tdata = item;
      req_tuser = action;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (action == ACT_WRITE) begin
         write_count++;
         if (item.x < MAX_SRC_WIDTH && item.y < MAX_SRC_HEIGHT)
            source_store[item.y * MAX_SRC_WIDTH + item.x] = pixel;
      end else begin
         request_count++;
         item.pixel = box_average(item.x, item.y, valid);
         if (valid) expected_pixels.push_back(item);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] index, input int unsigned value);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_SRC_WIDTH:  cfg_src_w = value[SSZ_W-1:0];
         CSR_SRC_HEIGHT: cfg_src_h = value[SSZ_W-1:0];
         CSR_DST_WIDTH:  cfg_dst_w = value[DSZ_W-1:0];
         CSR_DST_HEIGHT: cfg_dst_h = value[DSZ_W-1:0];
         CSR_BPP:        cfg_bpp = value[BPP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh, input int unsigned bpp);
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      write_reg(CSR_BPP, bpp);
      config_count++;
   endtask

   // Writes every source pixel that the current sizes can reach.
   task automatic fill_source(input bit extremes);
      int unsigned sw, sh;
      sw = (cfg_src_w == 0) ? 1 : ((cfg_src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : cfg_src_w);
      sh = (cfg_src_h == 0) ? 1 : ((cfg_src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : cfg_src_h);
      for (int unsigned yy = 0; yy < sh; yy++)
         for (int unsigned xx = 0; xx < sw; xx++)
            send_item(ACT_WRITE, xx, yy,
                      extremes ? (((xx + yy) % 2) ? 32'hFFFF_FFFF : 32'h0) : $urandom());
   endtask

   task automatic request_random(input int count);
      int unsigned dw, dh;
      dw = (cfg_dst_w == 0) ? 1 : ((cfg_dst_w > 4096) ? 4096 : cfg_dst_w);
      dh = (cfg_dst_h == 0) ? 1 : ((cfg_dst_h > 4096) ? 4096 : cfg_dst_h);
      for (int i = 0; i < count; i++)
         send_item(ACT_REQUEST, $urandom_range(0, dw - 1), $urandom_range(0, dh - 1), $urandom());
   endtask

   task automatic test_reset_sizes();
      // Boxes of the first and last destination pixel under the reset sizes, plus out-of-range writes and requests.
      send_item(ACT_WRITE, 0, 0, 32'hFFFF_FFFF);
      send_item(ACT_WRITE, 1, 0, 32'hFFFF_FFFF);
      send_item(ACT_WRITE, 0, 1, 32'hFFFF_FFFF);
      send_item(ACT_WRITE, 1, 1, 32'hFFFF_FFFE);
      send_item(ACT_WRITE, 510, 510, 32'h0);
      send_item(ACT_WRITE, 511, 510, 32'h0102_0304);
      send_item(ACT_WRITE, 510, 511, 32'h8040_2010);
      send_item(ACT_WRITE, 511, 511, 32'hFFFF_FFFF);
      send_item(ACT_WRITE, 512, 0, 32'hDEAD_BEEF);
      send_item(ACT_WRITE, 4095, 4095, 32'hDEAD_BEEF);
      send_item(ACT_WRITE, 0, 512, 32'hDEAD_BEEF);
      send_item(ACT_REQUEST, 0, 0, 32'hFFFF_FFFF);
      send_item(ACT_REQUEST, 255, 255, 32'h0);
      send_item(ACT_REQUEST, 256, 0, 32'h0);
      send_item(ACT_REQUEST, 0, 256, 32'h0);
      send_item(ACT_REQUEST, 4095, 4095, 32'h0);
   endtask

   task automatic test_size_extremes();
      configure(1, 1, 1, 1, 1);
      send_item(ACT_WRITE, 0, 0, 32'hA5C3_7E81);
      send_item(ACT_REQUEST, 0, 0, 32'h0);
      send_item(ACT_REQUEST, 1, 0, 32'h0);
      configure(0, 0, 0, 0, 0);
      send_item(ACT_REQUEST, 0, 0, 32'h0);
      configure(3, 2, 4096, 4096, 7);
      fill_source(1'b1);
      send_item(ACT_REQUEST, 4095, 4095, 32'h0);
      send_item(ACT_REQUEST, 0, 4095, 32'h0);
      configure(5, 3, 8191, 8191, 3);
      fill_source(1'b0);
      send_item(ACT_REQUEST, 4095, 4095, 32'h0);
      send_item(ACT_REQUEST, 2048, 1, 32'h0);
      write_reg(CSR_UNUSED, 13'h1FFF);
      send_item(ACT_REQUEST, 1000, 2000, 32'h0);
   endtask

   task automatic test_wide_boxes();
      // Oversized source widths saturate, giving one box across the full store width.
      configure(1023, 1, 1, 1, 4);
      fill_source(1'b0);
      send_item(ACT_REQUEST, 0, 0, 32'h0);
      configure(512, 1, 7, 1, 2);
      request_random(7);
      // An oversized height saturates, so the last row's box ends at the store edge.
      configure(1, 1023, 1, 256, 4);
      send_item(ACT_WRITE, 0, 1, $urandom());
      send_item(ACT_WRITE, 0, 510, $urandom());
      send_item(ACT_WRITE, 0, 511, $urandom());
      send_item(ACT_REQUEST, 0, 0, 32'h0);
      send_item(ACT_REQUEST, 0, 255, 32'h0);
   endtask

   task automatic test_backpressure();
      configure(4, 4, 2, 2, 4);
      fill_source(1'b0);
      wait_drained();
      hold_left = 400;
      request_random(8);
      wait_drained();
      request_random(6);
      wait_drained();
   endtask

   task automatic test_random_sizes();
      int unsigned sw, sh, pick;
      while (write_count + request_count < 1000) begin
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 8);
         configure(sw, sh,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 30),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 30),
                   $urandom_range(0, 7));
         fill_source(1'b0);
         for (int i = 0; i < 30; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               request_random(1);
            else if (pick == 7)
               send_item(ACT_REQUEST, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
            else if (pick == 8)
               send_item(ACT_WRITE, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1), $urandom());
            else
               send_item(ACT_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
         end
      end
   endtask

   task automatic test_streaming();
      configure(6, 6, 3, 4, 4);
      fill_source(1'b0);
      wait_drained();
      quiet = 1'b1;
      rx_gap = 0;
      tx_gap = 0;
      request_random(60);
   endtask

   initial begin
      cfg_src_w = 10'd512;
      cfg_src_h = 10'd512;
      cfg_dst_w = 13'd256;
      cfg_dst_h = 13'd256;
      cfg_bpp   = 3'd4;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_sizes();
      test_size_extremes();
      test_wide_boxes();
      test_backpressure();
      test_random_sizes();
      test_streaming();

      wait_drained();
      if (expected_pixels.size() != 0) report_mismatch("missing results", 0, 0);
      $display("Sent %0d pixel writes and %0d pixel requests over %0d size settings.",
               write_count, request_count, config_count);
      $display("Checked %0d averaged pixels, %0d mismatches.", result_count, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bair_pkg.sv
rtl/bair_div.sv
rtl/bair_lane.sv
rtl/bair_store.sv
rtl/box_average_image_resize_unit.sv
tb/tb_box_average_image_resize_unit.sv
